// ===== hw/rtl/lswc_pkg.sv =====
// ----------------------------------------------------------------------------
// lswc_pkg - shared definitions of the line segment window clipper
// Outcode bits, register indexes, reset window, pass limit and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lswc_pkg;

  // coordinate format
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS      = 4;

  // a segment is rejected as soon as this many clips have been made
  localparam int MAX_PASSES = 16;
  localparam int PASS_W     = $clog2(MAX_PASSES + 1);

  // outcode bits
  localparam logic [3:0] OC_LEFT   = 4'd1;
  localparam logic [3:0] OC_RIGHT  = 4'd2;
  localparam logic [3:0] OC_BOTTOM = 4'd4;
  localparam logic [3:0] OC_TOP    = 4'd8;

  // configuration register indexes
  localparam int         CFG_IDX_W  = 2;
  localparam logic [1:0] CFG_LEFT   = 2'd0;
  localparam logic [1:0] CFG_BOTTOM = 2'd1;
  localparam logic [1:0] CFG_RIGHT  = 2'd2;
  localparam logic [1:0] CFG_TOP    = 2'd3;

  // window after reset, in whole units scaled to fixed point
  localparam int WIN_LEFT_RST   = -30 * (2 ** FRAC_BITS);
  localparam int WIN_BOTTOM_RST =  10 * (2 ** FRAC_BITS);
  localparam int WIN_RIGHT_RST  =  20 * (2 ** FRAC_BITS);
  localparam int WIN_TOP_RST    =  60 * (2 ** FRAC_BITS);

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the input item
    logic setup;     // pick endpoint and edge, latch differences
    logic mul;       // form the product, seed the divider
    logic div_step;  // one restoring division step
    logic fix;       // add, saturate and move the endpoint
    logic out_load;  // fill the result register
    logic accept;    // accept flag for the result register
  } lswc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic both_inside;  // both outcodes zero
    logic share_side;   // outcodes share a bit
  } lswc_stat_t;

endpackage

// ===== hw/rtl/lswc_if.sv =====
// ----------------------------------------------------------------------------
// lswc_if - valid/ready channels of the line segment window clipper
// Input channel carries one segment, output channel one clipped result.
// ----------------------------------------------------------------------------
interface lswc_in_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lswc_out_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic                         accepted;
  logic signed [COORD_BITS-1:0] clip_start_x;
  logic signed [COORD_BITS-1:0] clip_start_y;
  logic signed [COORD_BITS-1:0] clip_end_x;
  logic signed [COORD_BITS-1:0] clip_end_y;

  modport source (output valid, accepted, clip_start_x, clip_start_y, clip_end_x,
                  clip_end_y, input ready);
  modport sink   (input valid, accepted, clip_start_x, clip_start_y, clip_end_x,
                  clip_end_y, output ready);
endinterface

// ===== hw/rtl/lswc_datapath.sv =====
// ----------------------------------------------------------------------------
// lswc_datapath - window registers, endpoints and intersection arithmetic
// Holds the segment, derives outcodes, and computes one edge intersection
// per clip with a single multiplier and a bit-serial restoring divider.
// ----------------------------------------------------------------------------
module lswc_datapath import lswc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  lswc_cmd_t                    cmd,
  output lswc_stat_t                   stat,
  output logic                         out_accepted,
  output logic signed [COORD_BITS-1:0] out_clip_start_x,
  output logic signed [COORD_BITS-1:0] out_clip_start_y,
  output logic signed [COORD_BITS-1:0] out_clip_end_x,
  output logic signed [COORD_BITS-1:0] out_clip_end_y
);

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int REM_W  = DIFF_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam logic signed [SUM_W-1:0] CMAX = SUM_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] CMIN = -CMAX - SUM_W'(1);

  // window registers
  logic signed [COORD_BITS-1:0] win_left_r, win_bottom_r, win_right_r, win_top_r;
  // endpoints
  logic signed [COORD_BITS-1:0] x0_r, y0_r, x1_r, y1_r;
  // per-clip operands
  logic                         first_r, axis_x_r, neg_r;
  logic signed [COORD_BITS-1:0] edge_r, b0_r;
  logic [DIFF_W-1:0]            mdb_r, mdn_r, mdd_r;
  // divider
  logic [PROD_W-1:0]            quo_r;
  logic [REM_W-1:0]             rem_r;
  // result register
  logic                         acc_out_r;
  logic signed [COORD_BITS-1:0] ox0_r, oy0_r, ox1_r, oy1_r;

  logic [3:0]                   code0, code1, code_sel;
  logic                         sel_first, axis_x;
  logic signed [COORD_BITS-1:0] edge_v, a0, a1, b0, b1;
  logic signed [DIFF_W-1:0]     db, dn, dd;
  logic [REM_W-1:0]             shifted;
  logic [REM_W:0]               trial;
  logic [PROD_W-1:0]            quo_fix;
  logic signed [SUM_W-1:0]      sum;
  logic signed [COORD_BITS-1:0] sat, new_x, new_y;

  function automatic logic [3:0] calc_code(
    input logic signed [COORD_BITS-1:0] x,
    input logic signed [COORD_BITS-1:0] y,
    input logic signed [COORD_BITS-1:0] l,
    input logic signed [COORD_BITS-1:0] r,
    input logic signed [COORD_BITS-1:0] b,
    input logic signed [COORD_BITS-1:0] t
  );
    logic [3:0] c;
    c = '0;
    if (x < l) begin
      c = c | OC_LEFT;
    end else if (x > r) begin
      c = c | OC_RIGHT;
    end
    if (y < b) begin
      c = c | OC_BOTTOM;
    end else if (y > t) begin
      c = c | OC_TOP;
    end
    return c;
  endfunction

  function automatic logic [DIFF_W-1:0] magn(input logic signed [DIFF_W-1:0] v);
    return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
  endfunction

  // outcodes of both endpoints
  assign code0 = calc_code(x0_r, y0_r, win_left_r, win_right_r, win_bottom_r, win_top_r);
  assign code1 = calc_code(x1_r, y1_r, win_left_r, win_right_r, win_bottom_r, win_top_r);
  assign stat.both_inside = (code0 == '0) && (code1 == '0);
  assign stat.share_side  = |(code0 & code1);

  // choose the endpoint to move and the edge it moves to
  assign sel_first = (code0 != '0);
  assign code_sel  = sel_first ? code0 : code1;

  always_comb begin
    if ((code_sel & OC_LEFT) != '0) begin
      axis_x = 1'b1;
      edge_v = win_left_r;
    end else if ((code_sel & OC_RIGHT) != '0) begin
      axis_x = 1'b1;
      edge_v = win_right_r;
    end else if ((code_sel & OC_BOTTOM) != '0) begin
      axis_x = 1'b0;
      edge_v = win_bottom_r;
    end else begin
      axis_x = 1'b0;
      edge_v = win_top_r;
    end
  end

  assign a0 = axis_x ? x0_r : y0_r;
  assign a1 = axis_x ? x1_r : y1_r;
  assign b0 = axis_x ? y0_r : x0_r;
  assign b1 = axis_x ? y1_r : x1_r;
  assign db = DIFF_W'(b1) - DIFF_W'(b0);
  assign dn = DIFF_W'(edge_v) - DIFF_W'(a0);
  assign dd = DIFF_W'(a1) - DIFF_W'(a0);

  // one restoring division step
  assign shifted = {rem_r[REM_W-2:0], quo_r[PROD_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, mdd_r};

  // signed sum and saturation; a zero divisor gives a zero quotient
  assign quo_fix = (mdd_r == '0) ? '0 : quo_r;
  assign sum     = SUM_W'(b0_r) + (neg_r ? -SUM_W'(quo_fix) : SUM_W'(quo_fix));

  always_comb begin
    if (sum > CMAX) begin
      sat = CMAX[COORD_BITS-1:0];
    end else if (sum < CMIN) begin
      sat = CMIN[COORD_BITS-1:0];
    end else begin
      sat = sum[COORD_BITS-1:0];
    end
  end

  assign new_x = axis_x_r ? edge_r : sat;
  assign new_y = axis_x_r ? sat : edge_r;

  // window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r   <= COORD_BITS'(WIN_LEFT_RST);
      win_bottom_r <= COORD_BITS'(WIN_BOTTOM_RST);
      win_right_r  <= COORD_BITS'(WIN_RIGHT_RST);
      win_top_r    <= COORD_BITS'(WIN_TOP_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEFT:   win_left_r   <= cfg_data;
        CFG_BOTTOM: win_bottom_r <= cfg_data;
        CFG_RIGHT:  win_right_r  <= cfg_data;
        CFG_TOP:    win_top_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // endpoints, operands, divider and result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0_r <= in_start_x;
      y0_r <= in_start_y;
      x1_r <= in_end_x;
      y1_r <= in_end_y;
    end
    if (cmd.setup) begin
      first_r  <= sel_first;
      axis_x_r <= axis_x;
      edge_r   <= edge_v;
      b0_r     <= b0;
      neg_r    <= db[DIFF_W-1] ^ dn[DIFF_W-1] ^ dd[DIFF_W-1];
      mdb_r    <= magn(db);
      mdn_r    <= magn(dn);
      mdd_r    <= magn(dd);
    end
    if (cmd.mul) begin
      quo_r <= PROD_W'(mdb_r) * PROD_W'(mdn_r);
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      if (!trial[REM_W]) begin
        rem_r <= trial[REM_W-1:0];
        quo_r <= {quo_r[PROD_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted;
        quo_r <= {quo_r[PROD_W-2:0], 1'b0};
      end
    end
    if (cmd.fix) begin
      if (first_r) begin
        x0_r <= new_x;
        y0_r <= new_y;
      end else begin
        x1_r <= new_x;
        y1_r <= new_y;
      end
    end
    if (cmd.out_load) begin
      acc_out_r <= cmd.accept;
      ox0_r     <= cmd.accept ? x0_r : '0;
      oy0_r     <= cmd.accept ? y0_r : '0;
      ox1_r     <= cmd.accept ? x1_r : '0;
      oy1_r     <= cmd.accept ? y1_r : '0;
    end
  end

  assign out_accepted     = acc_out_r;
  assign out_clip_start_x = ox0_r;
  assign out_clip_start_y = oy0_r;
  assign out_clip_end_x   = ox1_r;
  assign out_clip_end_y   = oy1_r;

endmodule

// ===== hw/rtl/lswc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lswc_ctrl - sequencer of the line segment window clipper
// Runs the test/clip passes, times the serial divider and owns the
// handshakes of both channels.
// ----------------------------------------------------------------------------
module lswc_ctrl import lswc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  lswc_stat_t stat,
  output lswc_cmd_t  cmd
);

  localparam int PROD_W = 2 * (COORD_BITS + 1);
  localparam int CNT_W  = $clog2(PROD_W);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECIDE = 7'b0000010,
    S_SETUP  = 7'b0000100,
    S_MUL    = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_FIX    = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [PASS_W-1:0]   pass_r, pass_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                acc_r, acc_nxt;
  logic                out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.accept    = acc_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          pass_nxt  = '0;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        // the pass limit wins over a final trivial accept
        if (pass_r == PASS_W'(MAX_PASSES)) begin
          acc_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else if (stat.both_inside) begin
          acc_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else if (stat.share_side) begin
          acc_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = CNT_W'(PROD_W - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_FIX;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_FIX: begin
        cmd.fix   = 1'b1;
        pass_nxt  = pass_r + PASS_W'(1);
        state_nxt = S_DECIDE;
      end
      S_DONE: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass_r      <= '0;
      cnt_r       <= '0;
      acc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      cnt_r       <= cnt_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // an accepted item goes straight to the first test
  a_load_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DECIDE))
    else $error("accepted item did not start a test pass");

  // the divider always runs its full length
  a_div_seed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |=> (state_r == S_DIV) && (cnt_r == CNT_W'(PROD_W - 1)))
    else $error("divider counter not seeded");

  // pass count stays within the limit
  a_pass_limit: assert property (@(posedge clk) disable iff (!rst_n)
    pass_r <= PASS_W'(MAX_PASSES))
    else $error("pass counter beyond limit");

  // each clip advances the pass count by one and returns to the test
  a_fix_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIX) |=> (state_r == S_DECIDE) && (pass_r == $past(pass_r) + 1))
    else $error("clip pass not counted");

  // a result appears only when a finished item is handed over
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result valid without a finished item");

endmodule

// ===== hw/rtl/line_segment_window_clipper_unit.sv =====
// ----------------------------------------------------------------------------
// line_segment_window_clipper_unit - Cohen-Sutherland segment clipper
// Clips a segment against an axis-aligned window held in four registers.
//
// Usage:
//  - in_ch (valid/ready) takes one segment: start_x, start_y, end_x, end_y,
//    signed fixed point. out_ch gives accepted and the clipped endpoints,
//    which are zero for a rejected segment.
//  - cfg_we/cfg_index/cfg_data write the window: 0 left, 1 bottom, 2 right,
//    3 top. Write only while the block is idle.
//  - One segment is worked on at a time. A segment that is accepted or
//    rejected without clipping goes through the decide and done states
//    before out valid rises. Each clip runs setup, multiply, the
//    bit-serial divider that forms the edge intersection one quotient bit
//    per cycle, and the endpoint fix; a segment needs at most four clips in
//    a proper window, and is rejected after 16 clips otherwise.
//  - The result waits in an output register; a new segment is taken while
//    it waits, and a finished segment holds until that register is free.
//  - Reset (rst_n low, synchronous) empties both channels and loads the
//    window -30.0, 10.0, 20.0, 60.0 (left, bottom, right, top).
// ----------------------------------------------------------------------------
module line_segment_window_clipper_unit import lswc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data,
  lswc_in_if.sink               in_ch,
  lswc_out_if.source            out_ch
);

  lswc_cmd_t  cmd;
  lswc_stat_t stat;

  // sequencer
  lswc_ctrl #(
    .COORD_BITS (COORD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic and storage
  lswc_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_start_x       (in_ch.start_x),
    .in_start_y       (in_ch.start_y),
    .in_end_x         (in_ch.end_x),
    .in_end_y         (in_ch.end_y),
    .cmd              (cmd),
    .stat             (stat),
    .out_accepted     (out_ch.accepted),
    .out_clip_start_x (out_ch.clip_start_x),
    .out_clip_start_y (out_ch.clip_start_y),
    .out_clip_end_x   (out_ch.clip_end_x),
    .out_clip_end_y   (out_ch.clip_end_y)
  );

endmodule
